[rtl/fvn_pkg.sv]
package fvn_pkg;

	// Defaults for the top-level parameters.
	localparam int TABLE_SIZE_DEF  = 256;
	localparam int MAX_OCTAVES_DEF = 8;

	// Field widths, fixed by the channel definitions.
	localparam int BYTE_W  = 8;
	localparam int COORD_W = 16;
	localparam int FREQ_W  = 16;
	localparam int OCT_W   = 4;
	localparam int NOISE_W = 16;
	localparam int CFG_W   = 16;

	// Reset values of the configuration registers.
	localparam logic [OCT_W-1:0]  OCTAVES_RST   = 4'd1;
	localparam logic [FREQ_W-1:0] FREQUENCY_RST = 16'd655;

	// Arithmetic constants.
	localparam int ROW_OFFSET   = 128;
	localparam int ONE_Q16      = 65536;
	localparam int SMOOTH_THREE = 3 * 65536;

	// Kind of request on the input channel.
	typedef enum logic [0:0] {
		REQ_LOAD   = 1'b0,
		REQ_SAMPLE = 1'b1
	} req_kind_t;

	// Configuration register indexes.
	typedef enum logic [0:0] {
		REG_OCTAVES   = 1'b0,
		REG_FREQUENCY = 1'b1
	} cfg_reg_t;

endpackage

[rtl/fvn_if.sv]
// Request channel: table loads and noise samples.
interface fvn_req_if import fvn_pkg::*;;
	logic                   valid;
	logic                   ready;
	req_kind_t              req_type;
	logic [BYTE_W-1:0]      table_index;
	logic [BYTE_W-1:0]      table_value;
	logic [COORD_W-1:0]     x_coord;
	logic [COORD_W-1:0]     y_coord;

	modport source (output valid, req_type, table_index, table_value, x_coord, y_coord,
		input ready);
	modport sink (input valid, req_type, table_index, table_value, x_coord, y_coord,
		output ready);
endinterface

// Result channel: one noise value per sample request.
interface fvn_res_if import fvn_pkg::*;;
	logic               valid;
	logic               ready;
	logic [NOISE_W-1:0] noise_value;

	modport source (output valid, noise_value, input ready);
	modport sink (input valid, noise_value, output ready);
endinterface

// Configuration write channel.
interface fvn_cfg_if import fvn_pkg::*;;
	logic             valid;
	logic             ready;
	cfg_reg_t         index;
	logic [CFG_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[rtl/fractal_value_noise_2d.sv]
// Channel  Role    Payload
// req      sink    req_type, table_index, table_value, x_coord, y_coord
// res      source  noise_value
// cfg      sink    index (octaves, frequency), data
//
// A load request writes one table byte in the cycle it is accepted; the block stays ready.
// A sample request keeps the block busy for a time that grows with the octave count and with
// the number of index wraps in the eight table reads of an octave (at most 8 for 256
// entries), as set by the one shared multiplier and the one-port table. The final cycle
// stretches while an earlier result still waits in the output register. Reset clears the
// sequencer and sets octaves to 1 and frequency to 655; the table is not cleared, so load it all.
module fractal_value_noise_2d import fvn_pkg::*; #(
	parameter int TABLE_SIZE  = TABLE_SIZE_DEF,
	parameter int MAX_OCTAVES = MAX_OCTAVES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	fvn_req_if.sink    req,
	fvn_res_if.source  res,
	fvn_cfg_if.sink    cfg
);

	// Table index width, and a wide enough width for the unwrapped corner addresses
	// (row byte + x + 1 is at most 511).
	localparam int IW = $clog2(TABLE_SIZE);
	localparam int SW = 10;
	localparam int CW = SW + 1;
	// Octave count width, octave accumulator width and divider width.
	localparam int OW = $clog2(MAX_OCTAVES + 1);
	localparam int NW = 24 + MAX_OCTAVES;
	localparam int VW = MAX_OCTAVES + 25;
	localparam int DCW = $clog2(NOISE_W);

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCALE_X,
		S_SCALE_Y,
		S_SCALE_END,
		S_CORNER,
		S_WRAP,
		S_LOOK,
		S_F2,
		S_HI,
		S_LO,
		S_W,
		S_B1,
		S_B2,
		S_B3,
		S_DIV,
		S_DONE
	} state_t;

	state_t state_q;

	// Configuration.
	logic [OCT_W-1:0]  octaves_q;
	logic [FREQ_W-1:0] freq_q;

	// Sample working registers.
	logic [COORD_W-1:0] x_q, y_q;
	logic [23:0]        cx_q, cy_q;
	logic [OW-1:0]      n_q, i_q;
	logic [1:0]         k_q;
	logic               look_col_q;
	logic               axis_q;
	logic [1:0]         bi_q;
	logic [SW-1:0]      addr_q;
	logic [BYTE_W-1:0]  rdata_q;
	logic [BYTE_W-1:0]  corner_q [4];
	logic [15:0]        lo16_q;
	logic [16:0]        wx_q, wy_q;
	logic [23:0]        lo_v_q, hi_v_q;
	logic [NW-1:0]      num_q;
	logic [49:0]        acc_q;
	logic [41:0]        prod_q;
	logic [VW-1:0]      rem_q, dsh_q;
	logic [NOISE_W-1:0] q_q;
	logic [DCW-1:0]     dc_q;
	logic               res_valid_q;
	logic [NOISE_W-1:0] noise_q;

	// Hash table, written by load requests and read one byte a cycle by the sequencer.
	logic [BYTE_W-1:0] hash_mem [TABLE_SIZE];

	logic              req_fire;
	logic              tbl_we;
	logic [15:0]       f_cur;
	logic [17:0]       g_cur;
	logic [16:0]       w_sel;
	logic [16:0]       one_minus_w;
	logic [23:0]       blend_a, blend_b;
	logic [23:0]       mul_a;
	logic [17:0]       mul_b;
	logic [49:0]       add_const;
	logic [49:0]       sum_all;
	logic [23:0]       blend_v;
	logic [16:0]       smooth_w;
	logic [VW-1:0]     den_w;
	logic [7:0]        ix, iy;

	assign req.ready   = (state_q == S_IDLE);
	assign cfg.ready   = 1'b1;
	assign res.valid   = res_valid_q;
	assign res.noise_value = noise_q;

	assign req_fire = req.valid && req.ready;
	assign tbl_we   = req_fire && (req.req_type == REQ_LOAD)
		&& (CW'(req.table_index) < CW'(TABLE_SIZE));

	always_ff @(posedge clk) begin
		if (tbl_we) begin
			hash_mem[IW'(req.table_index)] <= req.table_value;
		end
	end

	// The read port runs every cycle; the sequencer only uses the byte once the address has
	// been wrapped into the table.
	always_ff @(posedge clk) begin
		rdata_q <= hash_mem[addr_q[IW-1:0]];
	end

	// Integer lattice coordinates of the current octave.
	assign ix = cx_q[23:16];
	assign iy = cy_q[23:16];

	// Smoothstep operands: the fraction of the axis being worked on and 3 - 2f in Q2.16.
	assign f_cur = axis_q ? cy_q[15:0] : cx_q[15:0];
	assign g_cur = 18'(SMOOTH_THREE) - {1'b0, f_cur, 1'b0};

	// Blend operands. The first two blends mix the corner bytes along x, the third mixes
	// the two row results along y.
	always_comb begin
		case (bi_q)
			2'd0: begin
				blend_a = {corner_q[0], 16'h0000};
				blend_b = {corner_q[1], 16'h0000};
				w_sel   = wx_q;
			end
			2'd1: begin
				blend_a = {corner_q[2], 16'h0000};
				blend_b = {corner_q[3], 16'h0000};
				w_sel   = wx_q;
			end
			default: begin
				blend_a = lo_v_q;
				blend_b = hi_v_q;
				w_sel   = wy_q;
			end
		endcase
	end
	assign one_minus_w = 17'(ONE_Q16) - w_sel;

	// The shared multiplier. Its operands are chosen by the sequencer state and its product
	// is always registered before use.
	always_comb begin
		case (state_q)
			S_SCALE_X: begin
				mul_a = 24'(x_q);
				mul_b = 18'(freq_q);
			end
			S_SCALE_Y: begin
				mul_a = 24'(y_q);
				mul_b = 18'(freq_q);
			end
			S_F2: begin
				mul_a = 24'(f_cur);
				mul_b = 18'(f_cur);
			end
			S_HI: begin
				mul_a = 24'(prod_q[31:16]);
				mul_b = g_cur;
			end
			S_LO: begin
				mul_a = 24'(lo16_q);
				mul_b = g_cur;
			end
			S_B1: begin
				mul_a = blend_a;
				mul_b = 18'(one_minus_w);
			end
			S_B2: begin
				mul_a = blend_b;
				mul_b = 18'(w_sel);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// One adder closes both the smoothstep and the blend: accumulated partial product plus
	// the last product plus the rounding constant of that operation.
	assign add_const = (state_q == S_W) ? 50'h0_0000_8000_0000 : 50'h0_0000_0000_8000;
	assign sum_all   = acc_q + 50'(prod_q) + add_const;
	assign smooth_w  = sum_all[48:32];
	assign blend_v   = sum_all[39:16];

	// Normalising divisor: 256 * (2^n - 1). Summing the octaves most significant first with
	// a doubling accumulator scales both sides of the division by the same power of two.
	assign den_w = ((VW'(1) << n_q) - VW'(1)) << 8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			octaves_q <= OCTAVES_RST;
			freq_q    <= FREQUENCY_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_OCTAVES:   octaves_q <= cfg.data[OCT_W-1:0];
				REG_FREQUENCY: freq_q    <= cfg.data[FREQ_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			// In S_DONE the output register is refilled instead, so it is left to that state.
			if (res.valid && res.ready && (state_q != S_DONE)) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_fire && (req.req_type == REQ_SAMPLE)) begin
						x_q   <= req.x_coord;
						y_q   <= req.y_coord;
						i_q   <= '0;
						num_q <= '0;
						// An octave count of zero acts as one, too large a count as the maximum.
						if (octaves_q == '0) begin
							n_q <= OW'(1);
						end else if (5'(octaves_q) > 5'(MAX_OCTAVES)) begin
							n_q <= OW'(MAX_OCTAVES);
						end else begin
							n_q <= OW'(octaves_q);
						end
						state_q <= S_SCALE_X;
					end
				end
				S_SCALE_X: begin
					state_q <= S_SCALE_Y;
				end
				S_SCALE_Y: begin
					// Keep the low 8 integer bits and the 16 fraction bits.
					cx_q    <= prod_q[23:0];
					state_q <= S_SCALE_END;
				end
				S_SCALE_END: begin
					cy_q    <= prod_q[23:0];
					k_q     <= '0;
					state_q <= S_CORNER;
				end
				S_CORNER: begin
					// Row byte of the corner; the upper corners use the next row.
					addr_q     <= {2'b00, iy} + SW'(ROW_OFFSET) + SW'(k_q[1]);
					look_col_q <= 1'b0;
					state_q    <= S_WRAP;
				end
				S_WRAP: begin
					// Bring the address into the table by repeated subtraction; when it is
					// in range the read port picks the byte up on this edge.
					if (CW'(addr_q) >= CW'(TABLE_SIZE)) begin
						addr_q <= SW'(CW'(addr_q) - CW'(TABLE_SIZE));
					end else begin
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					if (!look_col_q) begin
						addr_q     <= {2'b00, rdata_q} + {2'b00, ix} + SW'(k_q[0]);
						look_col_q <= 1'b1;
						state_q    <= S_WRAP;
					end else begin
						corner_q[k_q] <= rdata_q;
						if (k_q == 2'd3) begin
							axis_q  <= 1'b0;
							state_q <= S_F2;
						end else begin
							k_q     <= k_q + 2'd1;
							state_q <= S_CORNER;
						end
					end
				end
				S_F2: begin
					state_q <= S_HI;
				end
				S_HI: begin
					lo16_q  <= prod_q[15:0];
					state_q <= S_LO;
				end
				S_LO: begin
					acc_q   <= {prod_q[33:0], 16'h0000};
					state_q <= S_W;
				end
				S_W: begin
					if (!axis_q) begin
						wx_q    <= smooth_w;
						axis_q  <= 1'b1;
						state_q <= S_F2;
					end else begin
						wy_q    <= smooth_w;
						bi_q    <= '0;
						state_q <= S_B1;
					end
				end
				S_B1: begin
					state_q <= S_B2;
				end
				S_B2: begin
					acc_q   <= 50'(prod_q);
					state_q <= S_B3;
				end
				S_B3: begin
					case (bi_q)
						2'd0: begin
							lo_v_q  <= blend_v;
							bi_q    <= 2'd1;
							state_q <= S_B1;
						end
						2'd1: begin
							hi_v_q  <= blend_v;
							bi_q    <= 2'd2;
							state_q <= S_B1;
						end
						default: begin
							num_q <= (num_q << 1) + NW'(blend_v);
							// Next octave: coordinates double and wrap within Q8.16.
							cx_q  <= {cx_q[22:0], 1'b0};
							cy_q  <= {cy_q[22:0], 1'b0};
							i_q   <= i_q + OW'(1);
							if ((i_q + OW'(1)) == n_q) begin
								state_q <= S_DIV;
							end else begin
								k_q     <= '0;
								state_q <= S_CORNER;
							end
						end
					endcase
				end
				S_DIV: begin
					// The first division cycle only loads the dividend with half the
					// divisor added for rounding; the quotient bits follow one a cycle.
					if (i_q == n_q) begin
						rem_q <= VW'(num_q) + (den_w >> 1);
						dsh_q <= den_w << (NOISE_W - 1);
						q_q   <= '0;
						dc_q  <= DCW'(NOISE_W - 1);
						i_q   <= '0;
					end else begin
						if (rem_q >= dsh_q) begin
							rem_q <= rem_q - dsh_q;
							q_q   <= {q_q[NOISE_W-2:0], 1'b1};
						end else begin
							q_q   <= {q_q[NOISE_W-2:0], 1'b0};
						end
						dsh_q <= dsh_q >> 1;
						if (dc_q == '0) begin
							state_q <= S_DONE;
						end else begin
							dc_q <= dc_q - DCW'(1);
						end
					end
				end
				S_DONE: begin
					// Hold the result back until the output register is free.
					if (!res_valid_q || res.ready) begin
						noise_q     <= q_q;
						res_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
